@@ hw/rtl/elm_pkg.sv @@
// Shared types and constants for the endstop limit monitor.
// Used by elm_cfg_regs, elm_check and endstop_limit_monitor; depends on nothing.
package elm_pkg;

  // Pins fitted on the board; an absent pin samples as inactive
  localparam logic [9:0] PINS_PRESENT = 10'h3FF;

  // Both dual Z switches qualified
  localparam logic [1:0] BOTH_Z = 2'b11;

  // Pin bit positions
  localparam int unsigned PIN_XMIN  = 0;
  localparam int unsigned PIN_XMAX  = 1;
  localparam int unsigned PIN_YMIN  = 2;
  localparam int unsigned PIN_YMAX  = 3;
  localparam int unsigned PIN_ZMIN  = 4;
  localparam int unsigned PIN_ZMAX  = 5;
  localparam int unsigned PIN_Z2MIN = 6;
  localparam int unsigned PIN_Z2MAX = 7;
  localparam int unsigned PIN_PROBE = 8;
  localparam int unsigned PIN_EMIN  = 9;

  // Axis and hit flag bit positions
  localparam int unsigned AXIS_X  = 0;
  localparam int unsigned AXIS_Y  = 1;
  localparam int unsigned AXIS_Z  = 2;
  localparam int unsigned AXIS_E  = 3;
  localparam int unsigned HIT_PRB = 4;

  // Kinematics codes; the unused code behaves as cartesian
  localparam logic [1:0] KIN_CARTESIAN = 2'd0;
  localparam logic [1:0] KIN_COREXY    = 2'd1;
  localparam logic [1:0] KIN_COREXZ    = 2'd2;

  // Dual Z codes; the unused code behaves as own pins
  localparam logic [1:0] DZ_SINGLE = 2'd0;
  localparam logic [1:0] DZ_OWN    = 2'd1;
  localparam logic [1:0] DZ_MIRROR = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_INVERT_MASK  = 3'd0;
  localparam logic [2:0] REG_KINEMATICS   = 3'd1;
  localparam logic [2:0] REG_DUAL_Z       = 3'd2;
  localparam logic [2:0] REG_PROBE_EN     = 3'd3;
  localparam logic [2:0] REG_E_CHECK_EN   = 3'd4;
  localparam logic [2:0] REG_DUAL_X_EN    = 3'd5;
  localparam logic [2:0] REG_X1_HOME_MIN  = 3'd6;
  localparam logic [2:0] REG_X2_HOME_MIN  = 3'd7;

  typedef struct packed {
    logic [9:0] invert_mask;
    logic [1:0] kinematics_mode;
    logic [1:0] dual_z_mode;
    logic       probe_enable;
    logic       e_check_enable;
    logic       dual_x_enable;
    logic       x1_home_min;
    logic       x2_home_min;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  pin_levels;
    logic [3:0]  motor_dir_neg;
    logic [2:0]  head_dir_neg;
    logic [31:0] steps_a;
    logic [31:0] steps_b;
    logic [31:0] steps_c;
    logic [31:0] steps_e;
    logic        active_carriage;
    logic        homing;
    logic        clear_hits;
  } item_t;

  typedef struct packed {
    logic [4:0] hit_flags;
    logic [3:0] triggered_axes;
    logic       kill_block;
    logic [9:0] sampled_bits;
  } result_t;

endpackage

@@ hw/rtl/elm_cfg_regs.sv @@
// Configuration register file of the endstop limit monitor.
// Depends on elm_pkg for cfg_t and the register indexes.
module elm_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [9:0]        cfg_data,
  output elm_pkg::cfg_t     cfg
);

  // Write one register per handshake; the port is always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_mask     <= '0;
      cfg.kinematics_mode <= elm_pkg::KIN_CARTESIAN;
      cfg.dual_z_mode     <= elm_pkg::DZ_SINGLE;
      cfg.probe_enable    <= 1'b0;
      cfg.e_check_enable  <= 1'b0;
      cfg.dual_x_enable   <= 1'b0;
      cfg.x1_home_min     <= 1'b1;
      cfg.x2_home_min     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        elm_pkg::REG_INVERT_MASK: cfg.invert_mask     <= cfg_data;
        elm_pkg::REG_KINEMATICS:  cfg.kinematics_mode <= cfg_data[1:0];
        elm_pkg::REG_DUAL_Z:      cfg.dual_z_mode     <= cfg_data[1:0];
        elm_pkg::REG_PROBE_EN:    cfg.probe_enable    <= cfg_data[0];
        elm_pkg::REG_E_CHECK_EN:  cfg.e_check_enable  <= cfg_data[0];
        elm_pkg::REG_DUAL_X_EN:   cfg.dual_x_enable   <= cfg_data[0];
        elm_pkg::REG_X1_HOME_MIN: cfg.x1_home_min     <= cfg_data[0];
        elm_pkg::REG_X2_HOME_MIN: cfg.x2_home_min     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/elm_check.sv @@
// Switch check logic for one stepper tick: sampling, direction gating, qualification.
// Depends on elm_pkg for cfg_t, item_t, result_t and pin positions.
module elm_check (
  input  elm_pkg::item_t   item,
  input  elm_pkg::cfg_t    cfg,
  input  logic [9:0]       last_bits,
  input  logic [4:0]       latched,
  output elm_pkg::result_t result
);

  logic [9:0] sample;
  logic [9:0] newval;
  logic [9:0] upd;
  logic [9:0] cur;
  logic [9:0] qual;
  logic       da, db, dc;
  logic       check_x, check_y, check_z;
  logic       x_neg, y_neg, z_neg;
  logic       home_min, dual_z, mirror_z;
  logic       sa_nz, sb_nz, sc_nz, se_nz;
  logic       xq, yq, zq1, zq2, pq, eq;
  logic       z_hit;
  logic [3:0] trig;
  logic [4:0] hits;

  assign da = item.motor_dir_neg[0];
  assign db = item.motor_dir_neg[1];
  assign dc = item.motor_dir_neg[2];

  assign sa_nz = (item.steps_a != '0);
  assign sb_nz = (item.steps_b != '0);
  assign sc_nz = (item.steps_c != '0);
  assign se_nz = (item.steps_e != '0);

  // Apply inversion and mask off absent pins
  assign sample = (item.pin_levels ^ cfg.invert_mask) & elm_pkg::PINS_PRESENT;

  assign dual_z   = (cfg.dual_z_mode != elm_pkg::DZ_SINGLE);
  assign mirror_z = (cfg.dual_z_mode == elm_pkg::DZ_MIRROR);

  // Pick direction and axis gating from the kinematics
  always_comb begin
    check_x = 1'b1;
    check_y = 1'b1;
    check_z = 1'b1;
    x_neg   = da;
    y_neg   = db;
    z_neg   = dc;
    if (cfg.kinematics_mode == elm_pkg::KIN_COREXY) begin
      check_x = (item.steps_a != item.steps_b) || (da == db);
      check_y = (item.steps_a != item.steps_b) || (da != db);
      x_neg   = item.head_dir_neg[0];
      y_neg   = item.head_dir_neg[1];
    end else if (cfg.kinematics_mode == elm_pkg::KIN_COREXZ) begin
      check_x = (item.steps_a != item.steps_c) || (da == dc);
      check_z = (item.steps_a != item.steps_c) || (da != dc);
      x_neg   = item.head_dir_neg[0];
      z_neg   = item.head_dir_neg[2];
    end
  end

  assign home_min = item.active_carriage ? cfg.x2_home_min : cfg.x1_home_min;

  // Select the switches sampled this tick
  always_comb begin
    upd = '0;
    upd[elm_pkg::PIN_XMIN]  = check_x & x_neg & (~cfg.dual_x_enable | home_min);
    upd[elm_pkg::PIN_XMAX]  = check_x & ~x_neg & (~cfg.dual_x_enable | ~home_min);
    upd[elm_pkg::PIN_YMIN]  = check_y & y_neg;
    upd[elm_pkg::PIN_YMAX]  = check_y & ~y_neg;
    upd[elm_pkg::PIN_ZMIN]  = check_z & z_neg;
    upd[elm_pkg::PIN_ZMAX]  = check_z & ~z_neg;
    upd[elm_pkg::PIN_Z2MIN] = check_z & z_neg & dual_z;
    upd[elm_pkg::PIN_Z2MAX] = check_z & ~z_neg & dual_z;
    upd[elm_pkg::PIN_PROBE] = check_z & z_neg & cfg.probe_enable;
    upd[elm_pkg::PIN_EMIN]  = cfg.e_check_enable;
  end

  // Mirror the Z switch onto Z2 in mirroring mode
  always_comb begin
    newval = sample;
    if (mirror_z) begin
      newval[elm_pkg::PIN_Z2MIN] = sample[elm_pkg::PIN_ZMIN];
      newval[elm_pkg::PIN_Z2MAX] = sample[elm_pkg::PIN_ZMAX];
    end
  end

  // Update sampled bits; a switch qualifies when active now and last time
  assign cur  = (last_bits & ~upd) | (newval & upd);
  assign qual = cur & last_bits & upd;

  assign xq  = qual[elm_pkg::PIN_XMIN] | qual[elm_pkg::PIN_XMAX];
  assign yq  = qual[elm_pkg::PIN_YMIN] | qual[elm_pkg::PIN_YMAX];
  assign zq1 = qual[elm_pkg::PIN_ZMIN] | qual[elm_pkg::PIN_ZMAX];
  assign zq2 = qual[elm_pkg::PIN_Z2MIN] | qual[elm_pkg::PIN_Z2MAX];
  assign pq  = qual[elm_pkg::PIN_PROBE];
  assign eq  = qual[elm_pkg::PIN_EMIN];

  assign z_hit = (zq1 | zq2) & sc_nz;

  // Stop axes with a qualified switch and steps left
  always_comb begin
    trig = '0;
    trig[elm_pkg::AXIS_X] = xq & sa_nz;
    trig[elm_pkg::AXIS_Y] = yq & sb_nz;
    trig[elm_pkg::AXIS_Z] = z_hit | (pq & sc_nz);
    trig[elm_pkg::AXIS_E] = eq & se_nz;
    hits = {pq, trig};
  end

  always_comb begin
    result.sampled_bits   = cur;
    result.triggered_axes = trig;
    result.hit_flags      = (item.clear_hits ? 5'b0 : latched) | hits;
    result.kill_block     = dual_z & z_hit &
                            (~item.homing | ({zq2, zq1} == elm_pkg::BOTH_Z));
  end

endmodule

@@ hw/rtl/endstop_limit_monitor.sv @@
// Top level of the endstop limit monitor: input register, check logic, result register.
// Depends on elm_pkg, elm_cfg_regs and elm_check.
//
// Takes one stepper tick per clock while in_stall is low and returns one result per
// tick; each tick passes through the input register and then the result register.
// The stored switch bits and latched hits update as a tick leaves the input
// register, in the same cycle the check logic reads them, so ticks follow each
// other with no gap. in_stall rises only while the result register holds an item
// that the receiver is stalling. Configuration writes are always ready.
module endstop_limit_monitor (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // Tick input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  pin_levels,
  input  logic [3:0]  motor_dir_neg,
  input  logic [2:0]  head_dir_neg,
  input  logic [31:0] steps_a,
  input  logic [31:0] steps_b,
  input  logic [31:0] steps_c,
  input  logic [31:0] steps_e,
  input  logic        active_carriage,
  input  logic        homing,
  input  logic        clear_hits,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  hit_flags,
  output logic [3:0]  triggered_axes,
  output logic        kill_block,
  output logic [9:0]  sampled_bits
);

  elm_pkg::cfg_t    cfg;
  elm_pkg::item_t   item;
  elm_pkg::result_t result;
  elm_pkg::result_t result_q;
  logic             item_valid;
  logic             advance;
  logic [9:0]       last_switch_bits;
  logic [4:0]       latched_hits;

  assign cfg_ready = 1'b1;

  elm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg        (cfg)
  );

  // Move the held item on when the result register is free or draining
  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = item_valid & ~advance;

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (~in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (~in_stall & in_valid) begin
      item <= '{pin_levels:      pin_levels,
                motor_dir_neg:   motor_dir_neg,
                head_dir_neg:    head_dir_neg,
                steps_a:         steps_a,
                steps_b:         steps_b,
                steps_c:         steps_c,
                steps_e:         steps_e,
                active_carriage: active_carriage,
                homing:          homing,
                clear_hits:      clear_hits};
    end
  end

  elm_check u_check (
    .item      (item),
    .cfg       (cfg),
    .last_bits (last_switch_bits),
    .latched   (latched_hits),
    .result    (result)
  );

  // Commit switch state and hits as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_switch_bits <= '0;
      latched_hits     <= '0;
    end else if (item_valid & advance) begin
      last_switch_bits <= result.sampled_bits;
      latched_hits     <= result.hit_flags;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance & item_valid) begin
      result_q <= result;
    end
  end

  assign hit_flags      = result_q.hit_flags;
  assign triggered_axes = result_q.triggered_axes;
  assign kill_block     = result_q.kill_block;
  assign sampled_bits   = result_q.sampled_bits;

  // A kill request always stops Z
  a_kill_stops_z: assert property (@(posedge clk) disable iff (rst)
    out_valid && kill_block |-> triggered_axes[elm_pkg::AXIS_Z])
    else $error("kill_block without Z stop");

  // Every stopped axis shows in the latched hits
  a_trig_latched: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((triggered_axes & hit_flags[3:0]) == triggered_axes))
    else $error("stopped axis missing from hit flags");

  // Kill only comes from dual Z
  a_kill_dual_z: assert property (@(posedge clk) disable iff (rst)
    out_valid && kill_block |-> (cfg.dual_z_mode != elm_pkg::DZ_SINGLE))
    else $error("kill_block with single Z");

  // Stored state reflects the item just delivered
  a_state_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(advance && item_valid) |->
      (last_switch_bits == sampled_bits) && (latched_hits == hit_flags))
    else $error("stored switch state out of step with result");

endmodule
